// ===== rtl/core/rss_pkg.sv =====
// Shared constants for the random sample set: widths, operation kinds and status codes.
package rss_pkg;

    localparam int VALUE_SPACE = 1024;
    localparam int VAL_W       = $clog2(VALUE_SPACE);
    localparam int CNT_W       = VAL_W + 1;
    localparam int RND_W       = 15;

    localparam int S_TDATA_W   = ((VAL_W + RND_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((VAL_W + CNT_W + 7) / 8) * 8;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // Entry of the per-value store: presence flag and slot in the dense store
    typedef struct packed {
        logic             present;
        logic [VAL_W-1:0] slot;
    } vent_t;

endpackage

// ===== rtl/core/rss_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module rss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rss_mod.sv =====
// Iterative restoring remainder unit: one dividend bit per cycle.
module rss_mod (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [rss_pkg::RND_W-1:0] dividend,
    input  logic [rss_pkg::CNT_W-1:0] divisor,
    output logic                      done,
    output logic [rss_pkg::CNT_W-1:0] remainder
);

    localparam int ITER_W = $clog2(rss_pkg::RND_W + 1);

    logic [rss_pkg::RND_W-1:0] dvd_reg, dvd_next;
    logic [rss_pkg::CNT_W-1:0] dsr_reg, dsr_next;
    logic [rss_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic [ITER_W-1:0]         iter_reg, iter_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [rss_pkg::CNT_W:0]   trial;

    // shift in the next dividend bit, subtract when it fits
    assign trial = {rem_reg, dvd_reg[rss_pkg::RND_W-1]};

    always_comb begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            iter_next = ITER_W'(rss_pkg::RND_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[rss_pkg::RND_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = rss_pkg::CNT_W'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = trial[rss_pkg::CNT_W-1:0];
            end
            iter_next = iter_reg - ITER_W'(1);
            if (iter_reg == ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/random_sample_set_unit.sv =====
// Top level of the random sample set: control sequencer around the value and dense stores.
// From input accept, kind three or an empty sample goes straight to the output state, an insert
// through the value entry lookup, a delete through lookup, last member move and presence drop,
// a sample through the bit-serial remainder unit and one dense store read. One item is in work at a
// time; a result moves to the output register once it is free, and waits there while the next item
// is taken. Once aresetn rises, sweep the value store clear, one entry a cycle, and take no item.
module random_sample_set_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rss_pkg::S_TDATA_W-1:0] s_tdata,  // value [9:0], random_number [24:10]
    input  logic [rss_pkg::KIND_W-1:0]    s_tuser,  // kind [1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rss_pkg::M_TDATA_W-1:0] m_tdata,  // sampled_value [9:0], member_count [20:10]
    output logic [rss_pkg::STATUS_W-1:0]  m_tuser   // status [1:0]
);

    localparam int VW = rss_pkg::VAL_W;
    localparam int CW = rss_pkg::CNT_W;

    // sequencer states
    localparam logic [3:0] S_CLR  = 4'd0;  // clearing sweep of the value store
    localparam logic [3:0] S_IDLE = 4'd1;  // wait for an item, read its value entry
    localparam logic [3:0] S_LOOK = 4'd2;  // value entry is back: insert or start delete
    localparam logic [3:0] S_LAST = 4'd3;  // last dense member is back: move it
    localparam logic [3:0] S_DROP = 4'd4;  // drop the deleted value's presence
    localparam logic [3:0] S_DIV  = 4'd5;  // wait for random_number mod count
    localparam logic [3:0] S_SMP  = 4'd6;  // dense member at the picked slot is back
    localparam logic [3:0] S_OUT  = 4'd7;  // hand the result to the output register

    logic [3:0]                   state_reg, state_next;
    logic [VW-1:0]                clr_idx_reg, clr_idx_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [rss_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [VW-1:0]                value_reg, value_next;
    logic [VW-1:0]                slot_reg, slot_next;
    logic [rss_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [VW-1:0]                res_sampled_reg, res_sampled_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [rss_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [VW-1:0]                m_sampled_reg, m_sampled_next;
    logic [CW-1:0]                m_count_reg, m_count_next;

    // value store: presence and slot per value
    logic                 vmem_we;
    logic [VW-1:0]        vmem_waddr;
    rss_pkg::vent_t       vmem_wdata;
    rss_pkg::vent_t       vmem_rdata;
    logic [VW:0]          vmem_rdata_raw;

    // dense store: packed members
    logic                 dmem_we;
    logic [VW-1:0]        dmem_waddr;
    logic [VW-1:0]        dmem_wdata;
    logic [VW-1:0]        dmem_raddr;
    logic [VW-1:0]        dmem_rdata;

    logic                 in_acc;
    logic [VW-1:0]        in_value;
    logic [rss_pkg::RND_W-1:0] in_rnd;
    logic                 div_start;
    logic                 div_done;
    logic [CW-1:0]        div_rem;
    logic                 out_free;
    logic [VW-1:0]        last_slot;

    assign in_value  = s_tdata[VW-1:0];
    assign in_rnd    = s_tdata[VW +: rss_pkg::RND_W];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_slot = VW'(count_reg - CW'(1));
    assign vmem_rdata = vmem_rdata_raw;

    // start the remainder unit only for a sample of a non-empty set
    assign div_start = in_acc && (s_tuser == rss_pkg::KIND_SAMPLE) && (count_reg != '0);

    rss_ram #(
        .WIDTH (VW + 1),
        .DEPTH (rss_pkg::VALUE_SPACE)
    ) u_value_ram (
        .clk   (aclk),
        .we    (vmem_we),
        .waddr (vmem_waddr),
        .wdata (vmem_wdata),
        .raddr (in_value),
        .rdata (vmem_rdata_raw)
    );

    rss_ram #(
        .WIDTH (VW),
        .DEPTH (rss_pkg::VALUE_SPACE)
    ) u_dense_ram (
        .clk   (aclk),
        .we    (dmem_we),
        .waddr (dmem_waddr),
        .wdata (dmem_wdata),
        .raddr (dmem_raddr),
        .rdata (dmem_rdata)
    );

    rss_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (in_rnd),
        .divisor   (count_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        count_next       = count_reg;
        kind_next        = kind_reg;
        value_next       = value_reg;
        slot_next        = slot_reg;
        res_status_next  = res_status_reg;
        res_sampled_next = res_sampled_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_status_next    = m_status_reg;
        m_sampled_next   = m_sampled_reg;
        m_count_next     = m_count_reg;

        vmem_we    = 1'b0;
        vmem_waddr = value_reg;
        vmem_wdata = '{present: 1'b0, slot: slot_reg};
        dmem_we    = 1'b0;
        dmem_waddr = slot_reg;
        dmem_wdata = dmem_rdata;
        dmem_raddr = '0;

        // output register drains independently of the sequencer
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_CLR: begin
                vmem_we      = 1'b1;
                vmem_waddr   = clr_idx_reg;
                vmem_wdata   = '{present: 1'b0, slot: '0};
                clr_idx_next = clr_idx_reg + VW'(1);
                if (clr_idx_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    kind_next        = s_tuser;
                    value_next       = in_value;
                    res_status_next  = rss_pkg::ST_OK;
                    res_sampled_next = '0;
                    case (s_tuser)
                        rss_pkg::KIND_INSERT, rss_pkg::KIND_DELETE: begin
                            state_next = S_LOOK;
                        end
                        rss_pkg::KIND_SAMPLE: begin
                            if (count_reg == '0) begin
                                res_status_next = rss_pkg::ST_EMPTY;
                                state_next      = S_OUT;
                            end else begin
                                state_next = S_DIV;
                            end
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                if (kind_reg == rss_pkg::KIND_INSERT) begin
                    if (vmem_rdata.present) begin
                        res_status_next = rss_pkg::ST_DUP;
                    end else begin
                        // append at the tail of the dense store
                        vmem_we    = 1'b1;
                        vmem_waddr = value_reg;
                        vmem_wdata = '{present: 1'b1, slot: count_reg[VW-1:0]};
                        dmem_we    = 1'b1;
                        dmem_waddr = count_reg[VW-1:0];
                        dmem_wdata = value_reg;
                        count_next = count_reg + CW'(1);
                    end
                    state_next = S_OUT;
                end else begin
                    if (!vmem_rdata.present) begin
                        res_status_next = rss_pkg::ST_NOTFOUND;
                        state_next      = S_OUT;
                    end else begin
                        slot_next  = vmem_rdata.slot;
                        dmem_raddr = last_slot;
                        state_next = S_LAST;
                    end
                end
            end
            S_LAST: begin
                // move the last member into the freed slot and repoint it
                dmem_we    = 1'b1;
                dmem_waddr = slot_reg;
                dmem_wdata = dmem_rdata;
                vmem_we    = 1'b1;
                vmem_waddr = dmem_rdata;
                vmem_wdata = '{present: 1'b1, slot: slot_reg};
                state_next = S_DROP;
            end
            S_DROP: begin
                // after the repoint, so a value that was itself last ends absent
                vmem_we    = 1'b1;
                vmem_waddr = value_reg;
                vmem_wdata = '{present: 1'b0, slot: slot_reg};
                count_next = count_reg - CW'(1);
                state_next = S_OUT;
            end
            S_DIV: begin
                dmem_raddr = div_rem[VW-1:0];
                if (div_done) begin
                    state_next = S_SMP;
                end
            end
            S_SMP: begin
                res_sampled_next = dmem_rdata;
                state_next       = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    m_status_next  = res_status_reg;
                    m_sampled_next = res_sampled_reg;
                    m_count_next   = count_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_idx_reg  <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        kind_reg        <= kind_next;
        value_reg       <= value_next;
        slot_reg        <= slot_next;
        res_status_reg  <= res_status_next;
        res_sampled_reg <= res_sampled_next;
        m_status_reg    <= m_status_next;
        m_sampled_reg   <= m_sampled_next;
        m_count_reg     <= m_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = rss_pkg::M_TDATA_W'({m_count_reg, m_sampled_reg});

endmodule

// ===== dv/tb_random_sample_set_unit.sv =====
// Self-checking testbench for random_sample_set_unit: insert, delete and sample against a predictor.
`timescale 1ns / 100ps

module tb_random_sample_set_unit;

    // The unused fourth operation code: the block answers ok and changes nothing
    localparam logic [rss_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
    // Cycles with no item taken and no result taken before the run is declared hung; covers the
    // presence sweep after reset plus the longest sample and receiver stall by far
    localparam int STALL_LIMIT = 4000;
    // Cycles to hold after the last result, well beyond the slowest operation
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [rss_pkg::KIND_W-1:0] kind;
        logic [rss_pkg::VAL_W-1:0]  value;
        logic [rss_pkg::RND_W-1:0]  rnd;
    } set_op_t;

    typedef struct packed {
        logic [rss_pkg::STATUS_W-1:0] status;
        logic [rss_pkg::VAL_W-1:0]    sampled;
        logic [rss_pkg::CNT_W-1:0]    members;
    } set_result_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [rss_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [rss_pkg::KIND_W-1:0]     s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [rss_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [rss_pkg::STATUS_W-1:0]   m_tuser;

    random_sample_set_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Predictor: its own copy of the set held as presence bits, slot
    // indexes and a packed member array
    // ------------------------------------------------------------------
    bit                        in_set   [rss_pkg::VALUE_SPACE];
    logic [rss_pkg::VAL_W-1:0] slot_of  [rss_pkg::VALUE_SPACE];
    logic [rss_pkg::VAL_W-1:0] packed_members [rss_pkg::VALUE_SPACE];
    int                        member_total = 0;
    int                        peak_members = 0;

    function automatic set_result_t apply_set_op(logic [rss_pkg::KIND_W-1:0] op,
                                                 logic [rss_pkg::VAL_W-1:0] v,
                                                 logic [rss_pkg::RND_W-1:0] rnd);
        set_result_t               res;
        logic [rss_pkg::VAL_W-1:0] hole;
        logic [rss_pkg::VAL_W-1:0] tail;
        res = '0;
        res.status = rss_pkg::ST_OK;
        case (op)
            rss_pkg::KIND_INSERT: begin
                if (in_set[v]) begin
                    res.status = rss_pkg::ST_DUP;
                end else begin
                    // append at the end of the packed array
                    packed_members[member_total] = v;
                    slot_of[v] = member_total[rss_pkg::VAL_W-1:0];
                    in_set[v] = 1'b1;
                    member_total++;
                end
            end
            rss_pkg::KIND_DELETE: begin
                if (!in_set[v]) begin
                    res.status = rss_pkg::ST_NOTFOUND;
                end else begin
                    // move the last member into the freed slot and fix its index
                    hole = slot_of[v];
                    tail = packed_members[member_total - 1];
                    packed_members[hole] = tail;
                    slot_of[tail] = hole;
                    in_set[v] = 1'b0;
                    member_total--;
                end
            end
            rss_pkg::KIND_SAMPLE: begin
                if (member_total == 0)
                    res.status = rss_pkg::ST_EMPTY;
                else
                    res.sampled = packed_members[int'(rnd) % member_total];
            end
            default: ;
        endcase
        res.members = member_total[rss_pkg::CNT_W-1:0];
        if (member_total > peak_members)
            peak_members = member_total;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Shared state between the sequence, the driver and the checker
    // ------------------------------------------------------------------
    set_op_t     op_queue[$];       // items waiting to be driven
    set_result_t due_results[$];    // predicted results not yet seen
    int          queued_items   = 0;
    int          accepted_items = 0;
    int          error_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          s_acc          = 1'b0;   // item taken at the last rising edge
    int          kind_seen[4];
    int          status_seen[4];

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge; hold an item until taken
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_items
        set_op_t it;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_acc) begin
            if (op_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                it = op_queue.pop_front();
                s_tdata  <= {{(rss_pkg::S_TDATA_W - rss_pkg::VAL_W - rss_pkg::RND_W){1'b0}},
                             it.rnd, it.value};
                s_tuser  <= it.kind;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: sample on the rising edge; compare results before taking
    // the new item, since a result always trails its own item
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        set_result_t got;
        set_result_t want;
        s_acc <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            got.status  = m_tuser;
            got.sampled = m_tdata[rss_pkg::VAL_W-1:0];
            got.members = m_tdata[rss_pkg::VAL_W+rss_pkg::CNT_W-1:rss_pkg::VAL_W];
            status_seen[got.status]++;
            if (due_results.size() == 0) begin
                error_count++;
                $display("%0t: result with none due: status %0d sampled %0d count %0d",
                         $time, got.status, got.sampled, got.members);
            end else begin
                want = due_results.pop_front();
                if (got.status !== want.status) begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                end
                if (got.sampled !== want.sampled) begin
                    error_count++;
                    $display("%0t: sampled_value expected %0d actual %0d",
                             $time, want.sampled, got.sampled);
                end
                if (got.members !== want.members) begin
                    error_count++;
                    $display("%0t: member_count expected %0d actual %0d",
                             $time, want.members, got.members);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            due_results.push_back(apply_set_op(s_tuser, s_tdata[rss_pkg::VAL_W-1:0],
                s_tdata[rss_pkg::VAL_W+rss_pkg::RND_W-1:rss_pkg::VAL_W]));
            kind_seen[s_tuser]++;
            accepted_items++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: drop the run if nothing moves for too long
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: track membership ahead of the driver so that most random
    // items are meaningful (inserts of absent values, deletes of members)
    // ------------------------------------------------------------------
    bit gen_member[rss_pkg::VALUE_SPACE];
    int gen_size = 0;

    task automatic queue_op(logic [rss_pkg::KIND_W-1:0] k, logic [rss_pkg::VAL_W-1:0] v,
                            logic [rss_pkg::RND_W-1:0] r);
        op_queue.push_back('{k, v, r});
        queued_items++;
        if (k == rss_pkg::KIND_INSERT && !gen_member[v]) begin
            gen_member[v] = 1'b1;
            gen_size++;
        end else if (k == rss_pkg::KIND_DELETE && gen_member[v]) begin
            gen_member[v] = 1'b0;
            gen_size--;
        end
    endtask

    // Draw any value of the value space
    function automatic logic [rss_pkg::VAL_W-1:0] any_value();
        return rss_pkg::VAL_W'($urandom_range(rss_pkg::VALUE_SPACE - 1));
    endfunction

    // Draw a value that is (or is not) a member; the caller makes sure one exists
    function automatic logic [rss_pkg::VAL_W-1:0] pick_value(bit want_member);
        logic [rss_pkg::VAL_W-1:0] v;
        v = any_value();
        while (gen_member[v] != want_member)
            v = any_value();
        return v;
    endfunction

    function automatic logic [rss_pkg::RND_W-1:0] draw_rnd();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return rss_pkg::RND_W'($urandom_range(15));
            default: return rss_pkg::RND_W'($urandom_range((1 << rss_pkg::RND_W) - 1));
        endcase
    endfunction

    task automatic random_mix(int n, int ins_pct, int del_pct, int smp_pct);
        int                        roll;
        logic [rss_pkg::VAL_W-1:0] v;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            v = any_value();
            if (roll < ins_pct) begin
                if (gen_size < rss_pkg::VALUE_SPACE && $urandom_range(99) < 85)
                    v = pick_value(1'b0);
                queue_op(rss_pkg::KIND_INSERT, v, draw_rnd());
            end else if (roll < ins_pct + del_pct) begin
                if (gen_size > 0 && $urandom_range(99) < 85)
                    v = pick_value(1'b1);
                queue_op(rss_pkg::KIND_DELETE, v, draw_rnd());
            end else if (roll < ins_pct + del_pct + smp_pct) begin
                queue_op(rss_pkg::KIND_SAMPLE, v, draw_rnd());
            end else begin
                queue_op(KIND_SPARE, v, draw_rnd());
            end
        end
    endtask

    // Hold the sequence until every queued item is taken and every result is back
    task automatic drain();
        while (accepted_items < queued_items || due_results.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        // Directed: empty set, both ends of the value range, duplicates,
        // absent deletes, deletes of first, last and only member, spare kind
        queue_op(rss_pkg::KIND_SAMPLE, 10'd0, 15'd0);
        queue_op(rss_pkg::KIND_DELETE, 10'd0, 15'd0);
        queue_op(KIND_SPARE, 10'd1023, 15'd32767);
        queue_op(rss_pkg::KIND_INSERT, 10'd0, 15'd0);
        queue_op(rss_pkg::KIND_INSERT, 10'd1023, 15'd32767);
        queue_op(rss_pkg::KIND_INSERT, 10'd0, 15'd0);
        queue_op(rss_pkg::KIND_SAMPLE, 10'd0, 15'd0);
        queue_op(rss_pkg::KIND_SAMPLE, 10'd1023, 15'd32767);
        queue_op(rss_pkg::KIND_DELETE, 10'd0, 15'd0);
        queue_op(rss_pkg::KIND_SAMPLE, 10'd0, 15'd0);
        queue_op(rss_pkg::KIND_DELETE, 10'd1023, 15'd32767);
        queue_op(rss_pkg::KIND_DELETE, 10'd1023, 15'd0);
        queue_op(rss_pkg::KIND_SAMPLE, 10'd0, 15'd32767);
        queue_op(rss_pkg::KIND_INSERT, 10'd512, 15'h2AAA);
        queue_op(rss_pkg::KIND_INSERT, 10'h155, 15'h5555);
        queue_op(rss_pkg::KIND_INSERT, 10'h2AA, 15'h2AAA);
        queue_op(rss_pkg::KIND_DELETE, 10'h2AA, 15'h5555);
        queue_op(rss_pkg::KIND_DELETE, 10'd512, 15'd0);
        queue_op(rss_pkg::KIND_SAMPLE, 10'd0, 15'd12345);
        queue_op(KIND_SPARE, 10'd0, 15'd0);
        queue_op(rss_pkg::KIND_DELETE, 10'h155, 15'd0);
        queue_op(rss_pkg::KIND_INSERT, 10'h155, 15'h5555);
        queue_op(rss_pkg::KIND_SAMPLE, 10'h2AA, 15'h2AAA);
        drain();

        // Random, no idling on either side
        random_mix(300, 40, 30, 25);
        drain();

        // Sender idles: fill the set to capacity, sampling along the way
        send_idle_pct = 59;
        while (gen_size < rss_pkg::VALUE_SPACE) begin
            if ($urandom_range(99) < 10)
                queue_op(rss_pkg::KIND_SAMPLE, any_value(), draw_rnd());
            else
                queue_op(rss_pkg::KIND_INSERT, pick_value(1'b0), draw_rnd());
        end
        queue_op(rss_pkg::KIND_SAMPLE, 10'd0, 15'd32767);
        queue_op(rss_pkg::KIND_SAMPLE, 10'd0, 15'd1023);
        queue_op(rss_pkg::KIND_INSERT, any_value(), draw_rnd());
        drain();

        // Receiver stalls: shrink the set again, mostly well-formed deletes
        send_idle_pct  = 0;
        recv_stall_pct = 59;
        random_mix(400, 10, 60, 25);
        drain();

        // Both sides idle now and then
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        random_mix(300, 40, 30, 25);
        drain();

        // Hold for any stray result to show up
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d items: %0d insert, %0d delete, %0d sample, %0d spare kind",
                 accepted_items, kind_seen[rss_pkg::KIND_INSERT],
                 kind_seen[rss_pkg::KIND_DELETE], kind_seen[rss_pkg::KIND_SAMPLE],
                 kind_seen[KIND_SPARE]);
        $display("results ok/dup/absent/empty %0d/%0d/%0d/%0d, membership peaked at %0d",
                 status_seen[rss_pkg::ST_OK], status_seen[rss_pkg::ST_DUP],
                 status_seen[rss_pkg::ST_NOTFOUND], status_seen[rss_pkg::ST_EMPTY],
                 peak_members);
        if (error_count == 0 && due_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results still due", error_count,
                     due_results.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== random_sample_set_unit.f =====
rtl/core/rss_pkg.sv
rtl/core/rss_ram.sv
rtl/core/rss_mod.sv
rtl/core/random_sample_set_unit.sv
dv/tb_random_sample_set_unit.sv
